// ----- sv/ccs_pkg.sv -----
// Shared types and character constants for the C comment stripper.
package ccs_pkg;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // One queued command: one or two output bytes for one input request.
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_cmd;

endpackage

// ----- sv/ccs_if.sv -----
// Valid/ready channel interfaces for the input and output byte streams.
interface ccs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_text;

    modport source (output valid, output char_in, output end_of_text, input ready);
    modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

interface ccs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       end_of_run;

    modport source (output valid, output char_out, output end_of_run, input ready);
    modport sink   (input valid, input char_out, input end_of_run, output ready);
endinterface

// ----- sv/ccs_front.sv -----
// Front end: accepts bytes, runs the comment scan state machine, issues commands.
module ccs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_char,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_ready,
    output logic          o_push,
    output ccs_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_NORMAL = 3'd0;
    localparam logic [2:0] S_SLASH  = 3'd1;
    localparam logic [2:0] S_LINE   = 3'd2;
    localparam logic [2:0] S_BLOCK  = 3'd3;
    localparam logic [2:0] S_STAR   = 3'd4;

    logic [2:0] r_mode;
    logic [2:0] n_mode;
    logic [2:0] scan_mode;
    logic       emit;
    logic       accept;
    logic [7:0] blank;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign blank   = (i_char == ccs_pkg::CH_NEWLINE) ? ccs_pkg::CH_NEWLINE
                                                     : ccs_pkg::CH_SPACE;

    always_comb begin
        scan_mode    = r_mode;
        emit         = 1'b0;
        o_cmd.two    = 1'b0;
        o_cmd.b0     = i_char;
        o_cmd.b1     = i_char;
        case (r_mode)
            S_SLASH: begin
                if (i_char == ccs_pkg::CH_SLASH) begin
                    scan_mode = S_LINE;
                end else if (i_char == ccs_pkg::CH_STAR) begin
                    scan_mode = S_BLOCK;
                end else begin
                    emit      = 1'b1;
                    o_cmd.two = 1'b1;
                    o_cmd.b0  = ccs_pkg::CH_SLASH;
                    scan_mode = S_NORMAL;
                end
            end
            S_LINE: begin
                emit     = 1'b1;
                o_cmd.b0 = blank;
                if (i_char == ccs_pkg::CH_NEWLINE) begin
                    scan_mode = S_NORMAL;
                end
            end
            S_BLOCK: begin
                emit     = 1'b1;
                o_cmd.b0 = blank;
                if (i_char == ccs_pkg::CH_STAR) begin
                    scan_mode = S_STAR;
                end
            end
            S_STAR: begin
                if (i_char == ccs_pkg::CH_SLASH) begin
                    scan_mode = S_NORMAL;
                end else begin
                    emit      = 1'b1;
                    o_cmd.b0  = blank;
                    scan_mode = (i_char == ccs_pkg::CH_STAR) ? S_STAR : S_BLOCK;
                end
            end
            default: begin
                if (i_char == ccs_pkg::CH_SLASH) begin
                    scan_mode = S_SLASH;
                end else begin
                    emit      = 1'b1;
                    scan_mode = S_NORMAL;
                end
            end
        endcase
        n_mode = scan_mode;
        if (i_last) begin
            // only reachable with nothing emitted yet: flush the held slash
            if (scan_mode == S_SLASH) begin
                emit     = 1'b1;
                o_cmd.b0 = ccs_pkg::CH_SLASH;
            end
            n_mode = S_NORMAL;
        end
    end

    assign o_push = accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_NORMAL;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

endmodule

// ----- sv/ccs_queue.sv -----
// Short command queue between the front end and the output sequencer.
module ccs_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ccs_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output ccs_pkg::t_cmd o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    ccs_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- sv/ccs_back.sv -----
// Back end: plays out one or two bytes per queued command.
module ccs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  ccs_pkg::t_cmd i_head,
    input  logic          i_ready,
    output logic          o_pop,
    output logic          o_valid,
    output logic [7:0]    o_char,
    output logic          o_last
);

    logic r_phase;
    logic fire;

    assign o_valid = !i_empty;
    assign o_char  = r_phase ? i_head.b1 : i_head.b0;
    assign o_last  = r_phase || !i_head.two;
    assign fire    = o_valid && i_ready;
    assign o_pop   = fire && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (fire) begin
            r_phase <= !o_last;
        end
    end

endmodule

// ----- sv/c_comment_stripper.sv -----
// Top level of the C comment stripper: front end, command queue, back end.
//
//  channel   dir  payload                  notes
//  i_in      in   char_in[8], end_of_text  one source byte per request
//  o_out     out  char_out[8], end_of_run  0..2 bytes per input request
//
// One input request per cycle while the queue has room; the scan state
// machine updates in the accept cycle. Output gives one byte per cycle while
// the receiver is ready; a two-byte request holds the back end for both bytes.
// Synchronous active-low reset returns the scan to normal and empties the queue.
// Input stalls only when the QUEUE_DEPTH-entry queue is full.
module c_comment_stripper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ccs_in_if.sink   i_in,
    ccs_out_if.source o_out
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    ccs_pkg::t_cmd cmd;
    ccs_pkg::t_cmd head;

    ccs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_char  (i_in.char_in),
        .i_last  (i_in.end_of_text),
        .i_full  (full),
        .o_ready (i_in.ready),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    ccs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    ccs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .i_ready (o_out.ready),
        .o_pop   (pop),
        .o_valid (o_out.valid),
        .o_char  (o_out.char_out),
        .o_last  (o_out.end_of_run)
    );

endmodule

// ----- tb/sv/ccs_strip_checker.sv -----
// Checker for the C comment stripper: predicts the stripped byte stream and compares it.
module ccs_strip_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ccs_in_if    i_in,
    ccs_out_if   i_out,
    output int   o_errors,
    output int   o_pending
);

    typedef enum logic [2:0] {
        SCAN_NORMAL,
        SCAN_SLASH,
        SCAN_LINE,
        SCAN_BLOCK,
        SCAN_STAR
    } t_scan;

    typedef struct packed {
        logic [7:0] char_out;
        logic       end_of_run;
    } t_out_byte;

    t_scan     scan;
    t_out_byte stripped_bytes[$];
    t_out_byte want;
    int        mismatch_count = 0;

    always_comb o_errors = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [7:0] comment_fill(input logic [7:0] ch);
        return (ch == ccs_pkg::CH_NEWLINE) ? ccs_pkg::CH_NEWLINE : ccs_pkg::CH_SPACE;
    endfunction

    // Advance the scan by one request and queue the bytes it must produce.
    function automatic void strip_byte(input logic [7:0] ch, input logic eot);
        logic [7:0] outs[$];
        case (scan)
            SCAN_SLASH: begin
                if (ch == ccs_pkg::CH_SLASH) begin
                    scan = SCAN_LINE;
                end else if (ch == ccs_pkg::CH_STAR) begin
                    scan = SCAN_BLOCK;
                end else begin
                    outs.push_back(ccs_pkg::CH_SLASH);
                    outs.push_back(ch);
                    scan = SCAN_NORMAL;
                end
            end
            SCAN_LINE: begin
                outs.push_back(comment_fill(ch));
                if (ch == ccs_pkg::CH_NEWLINE) scan = SCAN_NORMAL;
            end
            SCAN_BLOCK: begin
                outs.push_back(comment_fill(ch));
                if (ch == ccs_pkg::CH_STAR) scan = SCAN_STAR;
            end
            SCAN_STAR: begin
                if (ch == ccs_pkg::CH_SLASH) begin
                    scan = SCAN_NORMAL;
                end else begin
                    outs.push_back(comment_fill(ch));
                    scan = (ch == ccs_pkg::CH_STAR) ? SCAN_STAR : SCAN_BLOCK;
                end
            end
            default: begin
                if (ch == ccs_pkg::CH_SLASH) begin
                    scan = SCAN_SLASH;
                end else begin
                    outs.push_back(ch);
                    scan = SCAN_NORMAL;
                end
            end
        endcase
        // end of text flushes a held slash
        if (eot) begin
            if (scan == SCAN_SLASH) outs.push_back(ccs_pkg::CH_SLASH);
            scan = SCAN_NORMAL;
        end
        foreach (outs[k]) begin
            stripped_bytes.push_back('{char_out: outs[k], end_of_run: (k == outs.size() - 1)});
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan = SCAN_NORMAL;
            stripped_bytes.delete();
        end else begin
            if (i_in.valid && i_in.ready) strip_byte(i_in.char_in, i_in.end_of_text);
            if (i_out.valid && i_out.ready) begin
                if (stripped_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %h", i_out.char_out));
                end else begin
                    want = stripped_bytes.pop_front();
                    if (i_out.char_out !== want.char_out)
                        report_mismatch($sformatf("char_out %h, want %h",
                                                  i_out.char_out, want.char_out));
                    if (i_out.end_of_run !== want.end_of_run)
                        report_mismatch($sformatf("end_of_run %b, want %b (char %h)",
                                                  i_out.end_of_run, want.end_of_run,
                                                  want.char_out));
                end
            end
        end
        o_pending = stripped_bytes.size();
    end

endmodule

// ----- tb/sv/c_comment_stripper_test.sv -----
// Testbench top for the C comment stripper: stimulus, back-pressure and verdict.
module c_comment_stripper_test;

    localparam int IDLE_LIMIT = 1000;
    localparam int HOLD_CYCLES = 60;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ccs_in_if  in_ch();
    ccs_out_if out_ch();

    int errors;
    int pending;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_tag = 0;
    int hold_len = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int bytes_sent = 0;
    int send_pcts[4] = '{0, 55, 0, 28};
    int stall_pcts[4] = '{0, 0, 55, 28};

    logic [7:0] source_text[$];

    always #2 i_clk = ~i_clk;

    c_comment_stripper dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    ccs_strip_checker u_strip_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (in_ch),
        .i_out    (out_ch),
        .o_errors (errors),
        .o_pending(pending)
    );

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_tag != hold_seen) begin
            hold_seen <= hold_tag;
            hold_left <= hold_len;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("c_comment_stripper verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] ch, input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.char_in <= ch;
        in_ch.end_of_text <= eot;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic eot);
        for (int k = 0; k < s.len(); k++) send_byte(s[k], eot && (k == s.len() - 1));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] text_char();
        case ($urandom_range(9))
            0:       return ccs_pkg::CH_STAR;
            1:       return ccs_pkg::CH_SLASH;
            2:       return ccs_pkg::CH_NEWLINE;
            3:       return ccs_pkg::CH_SPACE;
            4, 5:    return 8'($urandom_range(255));
            default: return 8'($urandom_range(126, 33));
        endcase
    endfunction

    // Build one source file: mostly comments and text, some noise and fragments.
    task automatic compose_file();
        int         n_tok;
        int         n;
        logic [7:0] c;
        source_text.delete();
        n_tok = $urandom_range(6, 1);
        repeat (n_tok) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    n = $urandom_range(6, 1);
                    repeat (n) source_text.push_back(text_char());
                end
                3: begin
                    source_text.push_back(ccs_pkg::CH_SLASH);
                    source_text.push_back(ccs_pkg::CH_SLASH);
                    n = $urandom_range(6);
                    repeat (n) begin
                        c = text_char();
                        source_text.push_back((c == ccs_pkg::CH_NEWLINE) ? ccs_pkg::CH_SPACE
                                                                         : c);
                    end
                    source_text.push_back(ccs_pkg::CH_NEWLINE);
                end
                4, 5: begin
                    source_text.push_back(ccs_pkg::CH_SLASH);
                    source_text.push_back(ccs_pkg::CH_STAR);
                    n = $urandom_range(8);
                    repeat (n) source_text.push_back(text_char());
                    n = $urandom_range(3, 1);
                    repeat (n) source_text.push_back(ccs_pkg::CH_STAR);
                    source_text.push_back(ccs_pkg::CH_SLASH);
                end
                6: begin
                    c = text_char();
                    source_text.push_back(ccs_pkg::CH_SLASH);
                    source_text.push_back((c == ccs_pkg::CH_SLASH || c == ccs_pkg::CH_STAR)
                                          ? 8'h78 : c);
                end
                7: begin
                    n = $urandom_range(3, 1);
                    repeat (n) begin
                        source_text.push_back($urandom_range(1) ? ccs_pkg::CH_STAR
                                                                : ccs_pkg::CH_NEWLINE);
                    end
                end
                8: begin
                    n = $urandom_range(4, 1);
                    repeat (n) source_text.push_back(8'($urandom_range(255)));
                end
                default: begin
                    source_text.push_back(ccs_pkg::CH_SLASH);
                    if ($urandom_range(1)) source_text.push_back(ccs_pkg::CH_STAR);
                end
            endcase
        end
        if ($urandom_range(7) == 0) source_text.push_back(ccs_pkg::CH_SLASH);
    endtask

    task automatic send_file();
        foreach (source_text[k]) send_byte(source_text[k], k == source_text.size() - 1);
    endtask

    initial begin
        int target;
        in_ch.valid <= 1'b0;
        in_ch.char_in <= 8'h00;
        in_ch.end_of_text <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(ccs_pkg::CH_STAR, 1'b0);
        send_text("/x", 1'b0);
        send_text("/*a*\n**/", 1'b0);
        send_text("//b/\n", 1'b0);
        send_text("/", 1'b1);
        send_text("/*c", 1'b1);
        send_text("//", 1'b1);
        send_text("q", 1'b1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = send_pcts[phase];
            recv_stall_pct = stall_pcts[phase];
            target = bytes_sent + 200;
            while (bytes_sent < target) begin
                compose_file();
                send_file();
            end
            if (phase == 0) begin
                // long receiver hold-off while requests keep coming
                hold_len <= HOLD_CYCLES;
                hold_tag <= hold_tag + 1;
                target = bytes_sent + 40;
                while (bytes_sent < target) begin
                    compose_file();
                    send_file();
                end
            end
            wait_drained();
        end

        recv_stall_pct = 0;
        wait_drained();
        repeat (16) @(posedge i_clk);
        if (errors == 0) begin
            $display("c_comment_stripper verification clean");
        end else begin
            $display("c_comment_stripper verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/ccs_pkg.sv
sv/ccs_if.sv
sv/ccs_front.sv
sv/ccs_queue.sv
sv/ccs_back.sv
sv/c_comment_stripper.sv
tb/sv/ccs_strip_checker.sv
tb/sv/c_comment_stripper_test.sv
